FILE: rtl/core/query_response_latency_tracker_core_macros.svh
// Assertion helpers shared by the latency tracker RTL.
`ifndef QUERY_RESPONSE_LATENCY_TRACKER_CORE_MACROS_SVH
`define QUERY_RESPONSE_LATENCY_TRACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRLT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("latency tracker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QRLT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("latency tracker: next-cycle check failed");

`endif

FILE: rtl/core/qrlt_pkg.sv
package qrlt_pkg;

  localparam int unsigned DEFAULT_TABLE_ENTRIES = 64;

  // One slot of the pending table.
  typedef struct packed {
    logic        valid;
    logic [31:0] low_address;
    logic [31:0] high_address;
    logic [15:0] ident;
    logic [31:0] start_ms;
  } entry_t;

  // Lookup request handed to the table.
  typedef struct packed {
    logic        is_response;
    logic [31:0] low_address;
    logic [31:0] high_address;
    logic [15:0] ident;
    logic [31:0] arrival_ms;
  } tbl_req_t;

  // Outcome of one table lookup.
  typedef struct packed {
    logic        matched;
    logic        dropped;
    logic [31:0] latency_ms;
  } tbl_result_t;

endpackage

FILE: rtl/core/qrlt_table.sv
module qrlt_table
  import qrlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  tbl_req_t    req,
  output logic        ready,
  output logic        done,
  output tbl_result_t result
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [3:0] {
    TS_CLEAR = 4'b0001,
    TS_IDLE  = 4'b0010,
    TS_SCAN  = 4'b0100,
    TS_DONE  = 4'b1000
  } tbl_state_t;

  tbl_state_t  state;
  logic [AW:0] cnt;
  logic        rd_valid;
  logic [AW-1:0] rd_idx;
  entry_t      mem [TABLE_ENTRIES];
  entry_t      rd_data;
  logic        we;
  logic [AW-1:0] wa;
  entry_t      wd;
  tbl_req_t    req_q;
  logic        hit;
  logic [AW-1:0] hit_slot;
  logic [31:0] hit_start;
  logic        free_found;
  logic [AW-1:0] free_slot;
  logic        key_hit;
  logic        scan_end;

  // Single-port-write, single-port-read memory with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[cnt[AW-1:0]];
  end

  assign key_hit = rd_valid && rd_data.valid &&
                   (rd_data.low_address == req_q.low_address) &&
                   (rd_data.high_address == req_q.high_address) &&
                   (rd_data.ident == req_q.ident);
  assign scan_end = (cnt == (AW+1)'(TABLE_ENTRIES));
  assign ready    = (state == TS_IDLE);

  always_comb begin
    we = 1'b0;
    wa = cnt[AW-1:0];
    wd = '0;
    case (state)
      TS_CLEAR: begin
        we = 1'b1;
      end
      TS_DONE: begin
        if (req_q.is_response && hit) begin
          we = 1'b1;
          wa = hit_slot;
        end else if (!req_q.is_response && !hit && free_found) begin
          we = 1'b1;
          wa = free_slot;
          wd = '{valid: 1'b1, low_address: req_q.low_address,
                 high_address: req_q.high_address, ident: req_q.ident,
                 start_ms: req_q.arrival_ms};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= TS_CLEAR;
      cnt        <= '0;
      rd_valid   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= 1'b0;
      case (state)
        TS_CLEAR: begin
          if (cnt[AW-1:0] == AW'(TABLE_ENTRIES - 1)) begin
            cnt   <= '0;
            state <= TS_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        TS_IDLE: begin
          if (start) begin
            req_q      <= req;
            cnt        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= TS_SCAN;
          end
        end
        TS_SCAN: begin
          if (!scan_end) begin
            cnt      <= cnt + 1'b1;
            rd_valid <= 1'b1;
            rd_idx   <= cnt[AW-1:0];
          end
          if (key_hit && !hit) begin
            hit       <= 1'b1;
            hit_slot  <= rd_idx;
            hit_start <= rd_data.start_ms;
          end
          if (rd_valid && !rd_data.valid && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= rd_idx;
          end
          if (scan_end && !rd_valid) begin
            state <= TS_DONE;
          end
        end
        TS_DONE: begin
          done              <= 1'b1;
          result.matched    <= req_q.is_response && hit;
          result.dropped    <= !req_q.is_response && !hit && !free_found;
          result.latency_ms <= (req_q.is_response && hit) ?
                               (req_q.arrival_ms - hit_start) : 32'd0;
          state             <= TS_IDLE;
        end
        default: begin
          state <= TS_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/qrlt_div.sv
module qrlt_div
  import qrlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  // The upper dividend half must be below the divisor, so the quotient fits
  // in 32 bits and the partial remainder always fits in 32 bits.
  logic        busy;
  logic [4:0]  step;
  logic [31:0] rem;
  logic [31:0] div_q;
  logic [32:0] trial;
  logic        fits;

  assign trial    = {rem, quotient[31]};
  assign fits     = (trial >= {1'b0, div_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= dividend[63:32];
        quotient <= dividend[31:0];
        div_q    <= divisor;
      end else if (busy) begin
        rem      <= fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
        quotient <= {quotient[30:0], fits};
        step     <= step + 1'b1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/query_response_latency_tracker_core.sv
// Query/response latency tracker. Each request carries one parsed packet;
// queries are kept in a pending table keyed by (smaller address, larger
// address, transaction id), and a matching response removes its entry and
// updates the running sum, pair count and worst latency. Exactly one result
// is returned per request. The pending table lives in one synchronous
// memory that is scanned entry by entry during the lookup, which is
// followed by a preparation state, the one-bit-per-cycle average
// division when the count is nonzero and the quotient fits, and the
// loading of the output register. The next request is taken only once
// the output register has been loaded. After reset a clearing pass over
// all table entries runs before the first request is taken. A finished
// result waits in the output register while the next request is already
// accepted.
`include "query_response_latency_tracker_core_macros.svh"

module query_response_latency_tracker_core
  import qrlt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_response,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] transaction_id,
  input  logic [31:0] arrival_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        matched,
  output logic        dropped,
  output logic [31:0] latency_ms,
  output logic [31:0] average_ms,
  output logic [31:0] worst_ms,
  output logic [31:0] pair_count
);

  // One-hot control sequence for a single request.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } ctl_state_t;

  ctl_state_t  state;
  tbl_req_t    tbl_req;
  logic        tbl_ready;
  logic        tbl_done;
  tbl_result_t tbl_result;
  tbl_result_t res_q;
  logic        in_accept;
  logic [63:0] latency_sum;
  logic [31:0] matched_total;
  logic [31:0] worst_latency;
  logic [64:0] sum_next;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quotient;
  logic [31:0] average_q;

  assign in_ready  = (state == ST_IDLE) && tbl_ready;
  assign in_accept = in_valid && in_ready;

  // The key is order-independent so a query and its response meet.
  assign tbl_req.is_response  = is_response;
  assign tbl_req.low_address  = (source_address < dest_address) ? source_address
                                                                : dest_address;
  assign tbl_req.high_address = (source_address < dest_address) ? dest_address
                                                                : source_address;
  assign tbl_req.ident        = transaction_id;
  assign tbl_req.arrival_ms   = arrival_ms;

  qrlt_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept),
    .req   (tbl_req),
    .ready (tbl_ready),
    .done  (tbl_done),
    .result(tbl_result)
  );

  // The divider is only started when the quotient fits in 32 bits.
  assign div_start = (state == ST_PREP) && (matched_total != 32'd0) &&
                     (latency_sum[63:32] < matched_total);

  qrlt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(latency_sum),
    .divisor (matched_total),
    .done    (div_done),
    .quotient(div_quotient)
  );

  assign sum_next = {1'b0, latency_sum} + {33'd0, tbl_result.latency_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      latency_sum   <= '0;
      matched_total <= '0;
      worst_latency <= '0;
      out_valid     <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded instead.
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (tbl_done) begin
            res_q <= tbl_result;
            if (tbl_result.matched) begin
              // Sum and count saturate; the worst value keeps updating.
              latency_sum <= sum_next[64] ? '1 : sum_next[63:0];
              if (matched_total != '1) begin
                matched_total <= matched_total + 1'b1;
              end
              if (tbl_result.latency_ms > worst_latency) begin
                worst_latency <= tbl_result.latency_ms;
              end
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (matched_total == 32'd0) begin
            average_q <= '0;
            state     <= ST_EMIT;
          end else if (div_start) begin
            state <= ST_DIVIDE;
          end else begin
            // The quotient would not fit, so the average saturates.
            average_q <= '1;
            state     <= ST_EMIT;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            average_q <= div_quotient;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            matched    <= res_q.matched;
            dropped    <= res_q.dropped;
            latency_ms <= res_q.latency_ms;
            average_ms <= average_q;
            worst_ms   <= (matched_total != 32'd0) ? worst_latency : 32'd0;
            pair_count <= matched_total;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A request can never both match and be dropped.
  `QRLT_ASSERT_IMP(a_match_drop_excl, clk, rst, out_valid, !(matched && dropped))
  // With no pairs measured, the average and worst values read as zero.
  `QRLT_ASSERT_IMP(a_zero_stats, clk, rst, out_valid && (pair_count == 32'd0),
                   (average_ms == 32'd0) && (worst_ms == 32'd0))
  // A match always leaves a nonzero pair count.
  `QRLT_ASSERT_IMP(a_match_count, clk, rst, out_valid && matched, pair_count != 32'd0)
  // An accepted request always starts a table lookup.
  `QRLT_ASSERT_NXT(a_accept_lookup, clk, rst, in_accept, state == ST_LOOKUP)

endmodule
